FILE: rtl/life_generation_row_stream_core_macros.svh
// ----------------------------------------------------------------------------
// Life row stream assertion macros
// Shared concurrent assertion wrappers for the row stream core.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STREAM_CORE_MACROS_SVH
`define LIFE_GENERATION_ROW_STREAM_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LGRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define LGRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// Life row stream package
// Row width, result entry type and control bundles shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

  // Width of a row on the stream ports.
  localparam int unsigned ROW_W = 64;

  // One next-generation row as it leaves the block.
  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             final_row;
  } res_t;

  // Per-request control broadcast to every column cell.
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

  // Result writes into the output queue for one request.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/lgrs_cell.sv
// ----------------------------------------------------------------------------
// Life row stream column cell
// Holds one column of the two buffered rows and evaluates the B3/S23 rule for
// that column from its own bits and those of its left and right neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lgrs_pkg::cell_ctl_t ctl_i,
  input  wire logic [2:0]        cur_i,        // incoming row: right, self, left (MSB..LSB)
  input  wire logic [1:0]        nbr_above_i,  // [1] right neighbor, [0] left neighbor
  input  wire logic [1:0]        nbr_pend_i,   // [1] right neighbor, [0] left neighbor
  output logic                   above_o,
  output logic                   pend_o,
  output logic                   next_a_o,     // held row with incoming row below
  output logic                   next_b_o      // incoming row with dead row below
);
  import lgrs_pkg::*;

  logic above_q, above_d;
  logic pend_q, pend_d;

  function automatic logic life_rule(input logic [2:0] up, input logic [2:0] mid,
                                     input logic [2:0] down);
    logic [3:0] n;
    n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
      + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);
    return mid[1] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
  endfunction

  logic [2:0] above_win, pend_win;

  assign above_win = {nbr_above_i[1], above_q, nbr_above_i[0]};
  assign pend_win  = {nbr_pend_i[1], pend_q, nbr_pend_i[0]};

  assign next_a_o = life_rule(above_win, pend_win, cur_i);
  assign next_b_o = life_rule(pend_win, cur_i, 3'b000);
  assign above_o  = above_q;
  assign pend_o   = pend_q;

  always_comb begin
    above_d = above_q;
    pend_d  = pend_q;
    if (ctl_i.advance) begin
      if (ctl_i.clear) begin
        // drop both rows: back to the dead border
        above_d = 1'b0;
        pend_d  = 1'b0;
      end else begin
        above_d = pend_q;
        pend_d  = cur_i[1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      above_q <= above_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lgrs_out_queue.sv
// ----------------------------------------------------------------------------
// Life row stream output queue
// Three-entry shifting queue that takes up to two result rows per request and
// presents the oldest one on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_out_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lgrs_pkg::push_t push_i,
  input  wire lgrs_pkg::res_t  first_i,
  input  wire lgrs_pkg::res_t  second_i,
  input  wire logic           pop_i,
  output lgrs_pkg::res_t      head_o,
  output logic                valid_o,
  output logic                room_o,
  output logic [1:0]          count_o
);
  import lgrs_pkg::*;

  localparam int unsigned DEPTH = 3;

  res_t       ent_q [DEPTH];
  res_t       ent_d [DEPTH];
  logic [1:0] count_q, count_d;
  logic [1:0] base;

  assign base = count_q - 2'(pop_i);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop_i && i < DEPTH - 1) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_i.first && base == 2'(i)) begin
        ent_d[i] = first_i;
      end
      if (push_i.second && (base + 2'd1) == 2'(i)) begin
        ent_d[i] = second_i;
      end
    end
    count_d = count_q - 2'(pop_i) + 2'(push_i.first) + 2'(push_i.second);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = ent_q[0];
  assign valid_o = (count_q != 2'd0);
  // keep room for a two-row flush
  assign room_o  = (count_q <= 2'd1);
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: rtl/life_generation_row_stream_core.sv
// ----------------------------------------------------------------------------
// Life generation row stream core
// One B3/S23 generation over a grid streamed one row per request.
// ----------------------------------------------------------------------------
// Rows enter on the slave stream, one request per row, bit c being column c;
// tlast marks the bottom row. A row of GRID_WIDTH column cells holds the two
// previous rows and produces the next generation of the held row as soon as
// the row below arrives, so the block takes one row per cycle while the output
// queue has room; results are registered there. The bottom row flushes two
// results (the held row, then the bottom row over a dead border, tlast set)
// and returns the block to its reset state; a one-row grid yields one result.
// A three-entry output queue sets the rate: input is taken while it holds at
// most one row, so input waits for room after a flush and an output stall
// stops the input after at most three more rows. Input bits at or above
// GRID_WIDTH are ignored and read back as zero.
`default_nettype none

`include "life_generation_row_stream_core_macros.svh"

module life_generation_row_stream_core #(
  parameter int unsigned GRID_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] row_cells
  input  wire logic        s_axis_tlast,   // is_last_row
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] next_row_cells
  output logic             m_axis_tlast    // is_final
);
  import lgrs_pkg::*;

  logic s_acc, pop;
  logic holding_q, holding_d;

  cell_ctl_t ctl;
  push_t     push;
  res_t      res_first, res_second, head;
  logic      q_room;
  logic [1:0] q_count;

  logic [GRID_WIDTH+1:0] cur_pad, above_pad, pend_pad;
  logic [GRID_WIDTH-1:0] above_bits, pend_bits, next_a, next_b;
  logic [ROW_W-1:0]      row_a, row_b;

  assign s_acc = s_axis_tvalid & s_axis_tready;
  assign pop   = m_axis_tvalid & m_axis_tready;

  assign ctl.advance = s_acc;
  assign ctl.clear   = s_axis_tlast;

  // dead columns on both edges of the grid
  assign cur_pad   = {1'b0, s_axis_tdata[GRID_WIDTH-1:0], 1'b0};
  assign above_pad = {1'b0, above_bits, 1'b0};
  assign pend_pad  = {1'b0, pend_bits, 1'b0};

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    lgrs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cur_i       (cur_pad[c+2:c]),
      .nbr_above_i ({above_pad[c+2], above_pad[c]}),
      .nbr_pend_i  ({pend_pad[c+2], pend_pad[c]}),
      .above_o     (above_bits[c]),
      .pend_o      (pend_bits[c]),
      .next_a_o    (next_a[c]),
      .next_b_o    (next_b[c])
    );
  end

  assign row_a = ROW_W'(next_a);
  assign row_b = ROW_W'(next_b);

  // a held row always yields its successor; a last row adds the flush row
  assign push.first  = s_acc & (holding_q | s_axis_tlast);
  assign push.second = s_acc & holding_q & s_axis_tlast;

  assign res_first.cells      = holding_q ? row_a : row_b;
  assign res_first.final_row  = ~holding_q;
  assign res_second.cells     = row_b;
  assign res_second.final_row = 1'b1;

  always_comb begin
    holding_d = holding_q;
    if (s_acc) begin
      holding_d = ~s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q <= 1'b0;
    end else begin
      holding_q <= holding_d;
    end
  end

  lgrs_out_queue u_out_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (res_first),
    .second_i (res_second),
    .pop_i    (pop),
    .head_o   (head),
    .valid_o  (m_axis_tvalid),
    .room_o   (q_room),
    .count_o  (q_count)
  );

  assign s_axis_tready = q_room;
  assign m_axis_tdata  = head.cells;
  assign m_axis_tlast  = head.final_row;

  `LGRS_ASSERT(a_last_clears_hold, (s_acc && s_axis_tlast) |=> !holding_q,
               "last row left a row held")
  `LGRS_ASSERT_ALWAYS(a_idle_rows_dead, !holding_q |-> (pend_bits == '0),
                      "pending row not dead while idle")
  `LGRS_ASSERT(a_flush_two_rows,
               (s_acc && s_axis_tlast && holding_q && !pop)
                 |=> (q_count == $past(q_count) + 2'd2),
               "flush did not queue two rows")
  `LGRS_ASSERT(a_no_overflow, (q_count == 2'd3) |-> !s_axis_tready,
               "input taken with full queue")

endmodule

`default_nettype wire

FILE: test/life_generation_row_stream_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life generation row stream core testbench
// Streams grids of rows into the core and checks each next-generation row
// against a behavioral B3/S23 predictor. Directed patterns come first, then
// random grids, an output stall that fills the core, and a full-rate run.
// ----------------------------------------------------------------------------

module life_generation_row_stream_core_tb;

  localparam int unsigned GRID_W       = 64;
  localparam logic [63:0] GRID_MASK    = {64{1'b1}} >> (64 - GRID_W);
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_ROWS  = 1550;
  localparam int unsigned TOTAL_ROWS   = 1900;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] row_cells
  logic        s_axis_tlast;   // is_last_row
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [63:0] next_row_cells
  logic        m_axis_tlast;   // is_final

  // Predictor state: row above the held row, the held row, and its flag.
  logic [63:0] above_row;
  logic [63:0] held_row;
  bit          row_held;

  lgrs_pkg::res_t gen_rows_q[$];

  int unsigned errors;
  int unsigned rows_sent;
  int unsigned grids_sent;
  int unsigned gens_checked;
  int unsigned idle_cycles;

  bit          src_jitter;
  bit          sink_jitter;
  int unsigned sink_hold_req;

  life_generation_row_stream_core #(
    .GRID_WIDTH(GRID_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] life_next_row(input logic [63:0] up,
                                                input logic [63:0] mid,
                                                input logic [63:0] down);
    logic [63:0] nxt;
    int          n;
    int          k;
    nxt = '0;
    for (int c = 0; c < GRID_W; c++) begin
      n = 0;
      for (int dc = -1; dc <= 1; dc++) begin
        k = c + dc;
        // columns outside the grid are dead, no wrap
        if (k >= 0 && k < GRID_W) begin
          n += int'(up[k]) + int'(down[k]);
          if (dc != 0) n += int'(mid[k]);
        end
      end
      nxt[c] = mid[c] ? (n == 2 || n == 3) : (n == 3);
    end
    return nxt & GRID_MASK;
  endfunction

  task automatic push_generation(input logic [63:0] cells, input logic is_final);
    lgrs_pkg::res_t r;
    r.cells     = cells;
    r.final_row = is_final;
    gen_rows_q.push_back(r);
  endtask

  task automatic predict_row(input logic [63:0] cells, input logic last);
    logic [63:0] cur;
    cur = cells & GRID_MASK;
    if (!row_held) begin
      if (last) begin
        push_generation(life_next_row('0, cur, '0), 1'b1);
      end else begin
        above_row = '0;
        held_row  = cur;
        row_held  = 1'b1;
      end
    end else begin
      push_generation(life_next_row(above_row, held_row, cur), 1'b0);
      if (last) begin
        // flush the bottom row over a dead border, then back to reset
        push_generation(life_next_row(held_row, cur, '0), 1'b1);
        above_row = '0;
        held_row  = '0;
        row_held  = 1'b0;
      end else begin
        above_row = held_row;
        held_row  = cur;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t ns: MISMATCH %s: got %h expected %h", $time, what, got, want);
  endtask

  // Offer one row and hold it until the core takes it.
  task automatic send_row(input logic [63:0] cells, input logic last);
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cells;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_row(cells, last);
    rows_sent++;
  endtask

  function automatic logic [63:0] random_row();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return a & b & c;
      3:       return a | b;
      4:       return 64'd1 << $urandom_range(0, 63);
      5, 6:    return a & b;
      default: return a;
    endcase
  endfunction

  task automatic send_grid(input int unsigned height);
    for (int unsigned r = 0; r < height; r++) begin
      send_row(random_row(), r == height - 1);
    end
    grids_sent++;
  endtask

  task automatic test_directed_patterns();
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    // one-row grids
    send_row('0, 1'b1);
    send_row('1, 1'b1);
    send_row(64'h7, 1'b1);
    // vertical blinker
    send_row(64'h2, 1'b0);
    send_row(64'h2, 1'b0);
    send_row(64'h2, 1'b1);
    // opposite edge columns must not see each other
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    // solid grid
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // checkerboard
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b1);
    // two-row grid
    send_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
    grids_sent += 8;
  endtask

  task automatic test_random_grids();
    while (rows_sent < RANDOM_ROWS) begin
      src_jitter  = ($urandom_range(0, 4) != 0);
      sink_jitter = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) send_grid(1);
      else if ($urandom_range(0, 15) == 0) send_grid($urandom_range(20, 40));
      else send_grid($urandom_range(2, 10));
    end
  endtask

  task automatic test_output_backpressure();
    src_jitter    = 1'b0;
    sink_jitter   = 1'b0;
    sink_hold_req = 80;
    send_grid(16);
    send_grid(1);
    send_grid(5);
  endtask

  task automatic test_full_rate();
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    while (rows_sent < TOTAL_ROWS) begin
      send_grid($urandom_range(1, 12));
    end
  endtask

  initial begin : sink_drive
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req != 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall_left == 0 && sink_jitter && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    lgrs_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (gen_rows_q.size() == 0) begin
        report_mismatch("unexpected row", m_axis_tdata, '0);
      end else begin
        want = gen_rows_q.pop_front();
        gens_checked++;
        if (m_axis_tdata !== want.cells)
          report_mismatch("next_row_cells", m_axis_tdata, want.cells);
        if (m_axis_tlast !== want.final_row)
          report_mismatch("is_final", 64'(m_axis_tlast), 64'(want.final_row));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : main_seq
    errors        = 0;
    rows_sent     = 0;
    grids_sent    = 0;
    gens_checked  = 0;
    idle_cycles   = 0;
    src_jitter    = 1'b0;
    sink_jitter   = 1'b0;
    sink_hold_req = 0;
    above_row     = '0;
    held_row      = '0;
    row_held      = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_patterns();
    test_random_grids();
    test_output_backpressure();
    test_full_rate();

    s_axis_tvalid <= 1'b0;
    while (gen_rows_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d rows in %0d grids, %0d next-generation rows checked.",
             rows_sent, grids_sent, gens_checked);
    $display("Included edge columns, one-row grids, a long output stall and full rate.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: life_generation_row_stream_core.f
+incdir+rtl
rtl/lgrs_pkg.sv
rtl/lgrs_cell.sv
rtl/lgrs_out_queue.sv
rtl/life_generation_row_stream_core.sv
test/life_generation_row_stream_core_tb.sv
